// File: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/stw_pkg.sv
`default_nettype none

package stw_pkg;

	// field widths
	localparam int THR_W      = 10;
	localparam int HOLD_W     = 8;
	localparam int DIGIT_W    = 4;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// register reset values
	localparam logic [THR_W-1:0]  INACTIVE_THR_RST = 10'd300;
	localparam logic [THR_W-1:0]  PRESSED_THR_RST  = 10'd700;
	localparam logic [HOLD_W-1:0] MIN_HOLD_RST     = 8'd10;

	// counter limits
	localparam logic [HOLD_W-1:0]  HOLD_MAX     = 8'd255;
	localparam logic [DIGIT_W-1:0] DIGIT_TOP    = 4'd9;
	localparam logic [DIGIT_W-1:0] SEC_TENS_TOP = 4'd5;
	localparam logic [DIGIT_W-1:0] MINUTES_SAT  = 4'd10;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INACTIVE_THR = 2'd0,
		REG_PRESSED_THR  = 2'd1,
		REG_MIN_HOLD     = 2'd2
	} cfg_reg_t;

	// stopwatch mode
	typedef enum logic [1:0] {
		MODE_RESET = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_PAUSE = 2'd2
	} mode_t;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		digit_t minutes;
		digit_t sec_tens;
		digit_t sec_ones;
		digit_t hund_tens;
		digit_t hund_ones;
	} clock_time_t;

	typedef struct packed {
		logic              active;
		mode_t             mode;
		logic              held;
		logic [HOLD_W-1:0] hold_count;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		logic  changed;
		logic  clear_time;
	} btn_out_t;

endpackage

`default_nettype wire

// File: src/stw_button_logic.sv
`default_nettype none

module stw_button_logic #(
	parameter int ADC_BITS = 10
) (
	input  stw_pkg::ctrl_t                   ctrl,
	input  logic                             sample_valid,
	input  logic [ADC_BITS-1:0]              adc_sample,
	input  logic                             hold_tick,
	input  logic [stw_pkg::THR_W-1:0]        inactive_thr,
	input  logic [stw_pkg::THR_W-1:0]        pressed_thr,
	input  logic [stw_pkg::HOLD_W-1:0]       min_hold,
	output stw_pkg::btn_out_t                nxt
);
	import stw_pkg::*;

	localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

	logic [CMP_W-1:0] sample_ext;
	logic             new_active;
	logic             new_pressed;

	// classify the sample against both thresholds
	assign sample_ext  = CMP_W'(adc_sample);
	assign new_active  = sample_ext >= CMP_W'(inactive_thr);
	assign new_pressed = new_active && (sample_ext >= CMP_W'(pressed_thr));

	// level change, button edge and mode step, then hold tick
	always_comb begin
		nxt            = '0;
		nxt.ctrl       = ctrl;
		nxt.changed    = 1'b0;
		nxt.clear_time = 1'b0;
		if (sample_valid) begin
			if (nxt.ctrl.active != new_active) begin
				nxt.ctrl.active     = new_active;
				nxt.ctrl.mode       = MODE_RESET;
				nxt.ctrl.held       = 1'b0;
				nxt.ctrl.hold_count = '0;
				nxt.clear_time      = 1'b1;
				nxt.changed         = 1'b1;
			end
			if (nxt.ctrl.hold_count >= min_hold) begin
				if (new_pressed && !nxt.ctrl.held) begin
					nxt.ctrl.held       = 1'b1;
					nxt.ctrl.hold_count = '0;
				end else if (!new_pressed && nxt.ctrl.held) begin
					nxt.ctrl.held       = 1'b0;
					nxt.ctrl.hold_count = '0;
					unique case (nxt.ctrl.mode)
						MODE_PAUSE: begin
							nxt.ctrl.mode  = MODE_RESET;
							nxt.clear_time = 1'b1;
							nxt.changed    = 1'b1;
						end
						MODE_RUN: begin
							nxt.ctrl.mode = MODE_PAUSE;
							nxt.changed   = 1'b1;
						end
						MODE_RESET: begin
							nxt.ctrl.mode = MODE_RUN;
							nxt.changed   = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
		// saturating hold counter, only while switched on
		if (hold_tick && nxt.ctrl.active && (nxt.ctrl.hold_count != HOLD_MAX)) begin
			nxt.ctrl.hold_count = nxt.ctrl.hold_count + 8'd1;
		end
	end

endmodule

`default_nettype wire

// File: src/stw_time_counter.sv
`default_nettype none

module stw_time_counter (
	input  stw_pkg::clock_time_t cur,
	input  logic                 clear,
	input  logic                 advance,
	output stw_pkg::clock_time_t nxt
);
	import stw_pkg::*;

	// one bcd digit step: {carry, digit}
	function automatic logic [DIGIT_W:0] bump_digit(digit_t d, digit_t top);
		logic [DIGIT_W:0] r;
		if (d == top) begin
			r = {1'b1, {DIGIT_W{1'b0}}};
		end else begin
			r = {1'b0, d + 4'd1};
		end
		return r;
	endfunction

	// clear, then ripple the carry up through the digits
	always_comb begin
		logic [DIGIT_W:0] b;
		nxt = clear ? '0 : cur;
		b   = '0;
		if (advance && (nxt.minutes < MINUTES_SAT)) begin
			b = bump_digit(nxt.hund_ones, DIGIT_TOP);
			nxt.hund_ones = b[DIGIT_W-1:0];
			if (b[DIGIT_W]) begin
				b = bump_digit(nxt.hund_tens, DIGIT_TOP);
				nxt.hund_tens = b[DIGIT_W-1:0];
				if (b[DIGIT_W]) begin
					b = bump_digit(nxt.sec_ones, DIGIT_TOP);
					nxt.sec_ones = b[DIGIT_W-1:0];
					if (b[DIGIT_W]) begin
						b = bump_digit(nxt.sec_tens, SEC_TENS_TOP);
						nxt.sec_tens = b[DIGIT_W-1:0];
						if (b[DIGIT_W]) begin
							nxt.minutes = nxt.minutes + 4'd1;
							// saturated display
							if (nxt.minutes == MINUTES_SAT) begin
								nxt.sec_tens  = DIGIT_TOP;
								nxt.sec_ones  = DIGIT_TOP;
								nxt.hund_tens = DIGIT_TOP;
								nxt.hund_ones = DIGIT_TOP;
							end
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/stopwatch_button_controller_unit.sv
`default_nettype none
// Stopwatch controlled by one analog button (start / pause / reset).
// Input channel: item_valid / item_stall with sample_valid, adc_sample,
// hold_tick and centi_tick; a beat is taken when item_valid is high and
// item_stall low. Output channel: result_valid / result_stall carrying the
// active level, mode, state_changed flag and the time digits; one result
// beat per input beat, in order.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes a threshold
// or the minimum hold count at the clock edge; write only while idle.
// Path: a beat taken goes into the input register, and its result is
// loaded into the state register once the result register is free.
// Throughput: one beat per cycle while the receiver does not stall; the
// result register is the state register itself, updated by combinational classify and bcd logic.
// When the receiver stalls, the input register still takes one more beat,
// then item_stall is raised until the result is taken.
// Reset (arst_n low) clears the state to switched off, reset mode, time
// zero, and loads the default thresholds 300 and 700 and hold count 10.
`include "assert_macros.svh"

module stopwatch_button_controller_unit #(
	parameter int ADC_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic [stw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stw_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            sample_valid,
	input  logic [ADC_BITS-1:0]             adc_sample,
	input  logic                            hold_tick,
	input  logic                            centi_tick,
	// output channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            active,
	output logic [1:0]                      mode,
	output logic                            state_changed,
	output logic [stw_pkg::DIGIT_W-1:0]     minutes,
	output logic [stw_pkg::DIGIT_W-1:0]     sec_tens,
	output logic [stw_pkg::DIGIT_W-1:0]     sec_ones,
	output logic [stw_pkg::DIGIT_W-1:0]     hund_tens,
	output logic [stw_pkg::DIGIT_W-1:0]     hund_ones
);
	import stw_pkg::*;

	logic [THR_W-1:0]  inactive_thr_q;
	logic [THR_W-1:0]  pressed_thr_q;
	logic [HOLD_W-1:0] min_hold_q;

	logic                s1_valid_s1;
	logic                sample_valid_s1;
	logic [ADC_BITS-1:0] adc_sample_s1;
	logic                hold_tick_s1;
	logic                centi_tick_s1;

	ctrl_t       ctrl_q;
	clock_time_t time_q;
	logic        changed_q;
	logic        result_valid_q;

	btn_out_t    btn_nxt;
	clock_time_t time_nxt;
	logic        advance;
	logic        s1_go;
	logic        item_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inactive_thr_q <= INACTIVE_THR_RST;
			pressed_thr_q  <= PRESSED_THR_RST;
			min_hold_q     <= MIN_HOLD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INACTIVE_THR: inactive_thr_q <= cfg_data[THR_W-1:0];
				REG_PRESSED_THR:  pressed_thr_q  <= cfg_data[THR_W-1:0];
				REG_MIN_HOLD:     min_hold_q     <= cfg_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake: stage moves when the result register is free
	assign s1_go      = s1_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid_s1 && result_valid_q && result_stall;
	assign item_take  = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (item_take) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			sample_valid_s1 <= sample_valid;
			adc_sample_s1   <= adc_sample;
			hold_tick_s1    <= hold_tick;
			centi_tick_s1   <= centi_tick;
		end
	end

	// sample evaluation and hold counter
	stw_button_logic #(
		.ADC_BITS(ADC_BITS)
	) u_button (
		.ctrl         (ctrl_q),
		.sample_valid (sample_valid_s1),
		.adc_sample   (adc_sample_s1),
		.hold_tick    (hold_tick_s1),
		.inactive_thr (inactive_thr_q),
		.pressed_thr  (pressed_thr_q),
		.min_hold     (min_hold_q),
		.nxt          (btn_nxt)
	);

	// time counts only while on and running
	assign advance = centi_tick_s1 && btn_nxt.ctrl.active && (btn_nxt.ctrl.mode == MODE_RUN);

	stw_time_counter u_time (
		.cur     (time_q),
		.clear   (btn_nxt.clear_time),
		.advance (advance),
		.nxt     (time_nxt)
	);

	// state doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q         <= '0;
			time_q         <= '0;
			changed_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (s1_go) begin
			ctrl_q         <= btn_nxt.ctrl;
			time_q         <= time_nxt;
			changed_q      <= btn_nxt.changed;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// result beat
	assign result_valid  = result_valid_q;
	assign active        = ctrl_q.active;
	assign mode          = ctrl_q.mode;
	assign state_changed = changed_q;
	assign minutes       = time_q.minutes;
	assign sec_tens      = time_q.sec_tens;
	assign sec_ones      = time_q.sec_ones;
	assign hund_tens     = time_q.hund_tens;
	assign hund_ones     = time_q.hund_ones;

	// checks
	`ASSERT_IMPL(a_min_range, clk, arst_n, 1'b1, time_q.minutes <= MINUTES_SAT)
	`ASSERT_IMPL(a_sat_digits, clk, arst_n, time_q.minutes == MINUTES_SAT, time_q.sec_tens == DIGIT_TOP && time_q.sec_ones == DIGIT_TOP && time_q.hund_tens == DIGIT_TOP && time_q.hund_ones == DIGIT_TOP)
	`ASSERT_IMPL(a_off_idle, clk, arst_n, !ctrl_q.active, ctrl_q.mode == MODE_RESET && ctrl_q.hold_count == '0 && time_q == '0)
	`ASSERT_NEXT(a_chg_needs_sample, clk, arst_n, s1_go && !sample_valid_s1, !changed_q)

endmodule

`default_nettype wire
